// ===== rtl/core/jfs_pkg.sv =====
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared constants and the queue item type of the five-point Jacobi stencil.
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam int DATA_BITS   = 32;
  localparam int ROW_BITS    = 16;
  localparam int COL_BITS    = 10;
  localparam int RES_BITS    = 63;
  localparam int GW_BITS     = 11;
  localparam int GH_BITS     = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [GW_BITS-1:0] GRID_WIDTH_RST  = 11'd16;
  localparam logic [GH_BITS-1:0] GRID_HEIGHT_RST = 16'd16;

  localparam logic [RES_BITS-1:0] RES_CAP = {RES_BITS{1'b1}};

  typedef struct packed {
    logic                        last;
    logic signed [DATA_BITS-1:0] left;
    logic signed [DATA_BITS-1:0] up;
    logic signed [DATA_BITS-1:0] right;
    logic signed [DATA_BITS-1:0] down;
    logic signed [DATA_BITS-1:0] old;
    logic [ROW_BITS-1:0]         row;
    logic [COL_BITS-1:0]         col;
  } jfs_item_t;

endpackage

// ===== rtl/core/jfs_ram.sv =====
// ----------------------------------------------------------------------------
// jfs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module jfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// ===== rtl/core/jfs_queue.sv =====
// ----------------------------------------------------------------------------
// jfs_queue
// Small item queue between the stencil front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module jfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  jfs_pkg::jfs_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output jfs_pkg::jfs_item_t head
);
  import jfs_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  jfs_item_t     q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic [PW:0]   count_nxt;

  assign full  = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("item pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("item popped from an empty queue");
`endif

endmodule

// ===== rtl/core/jfs_front.sv =====
// ----------------------------------------------------------------------------
// jfs_front
// Raster counters, line buffers and classification of each incoming sample.
// ----------------------------------------------------------------------------
module jfs_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [jfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [jfs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [jfs_pkg::DATA_BITS-1:0] in_sample,
  output logic                              q_push,
  output jfs_pkg::jfs_item_t                q_item,
  input  logic                              q_full
);
  import jfs_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam logic [12:0] WMAX = 13'(MAX_WIDTH);

  logic [GW_BITS-1:0] grid_width_r;
  logic [GH_BITS-1:0] grid_height_r;
  logic               run_r;
  logic [CW-1:0]      col_r;
  logic [CW-1:0]      col_nxt;
  logic [ROW_BITS-1:0] row_r;
  logic [ROW_BITS-1:0] row_nxt;

  logic [12:0]        gw_ext;
  logic [12:0]        w_clamp;
  logic [WB-1:0]      w_eff;
  logic [GH_BITS-1:0] h_eff;
  logic               col_last;
  logic               row_last;
  logic               interior;
  logic               accept;

  logic [CW-1:0] rd_col;
  logic [CW-1:0] ua_addr;
  logic [CW-1:0] ub_addr;
  logic [CW-1:0] ma_addr;
  logic [CW-1:0] mb_addr;
  logic [VALUE_BITS-1:0] ua_q;
  logic [VALUE_BITS-1:0] ub_q;
  logic [VALUE_BITS-1:0] ma_q;
  logic [VALUE_BITS-1:0] mb_q;

  logic byp_ua_r;
  logic byp_ub_r;
  logic byp_ma_r;
  logic byp_mb_r;
  logic [VALUE_BITS-1:0] up_wd_r;
  logic [VALUE_BITS-1:0] mid_wd_r;

  logic signed [VALUE_BITS-1:0] xs;
  logic signed [VALUE_BITS-1:0] left_v;
  logic signed [VALUE_BITS-1:0] up_v;
  logic signed [VALUE_BITS-1:0] center_v;
  logic signed [VALUE_BITS-1:0] right_v;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[GW_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[GH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign gw_ext  = 13'(grid_width_r);
  assign w_clamp = (gw_ext < 13'd3) ? 13'd3 : ((gw_ext > WMAX) ? WMAX : gw_ext);
  assign w_eff   = WB'(w_clamp);
  assign h_eff   = (grid_height_r < 16'd3) ? 16'd3 : grid_height_r;

  assign col_last = (WB'(col_r) + WB'(1)) >= w_eff;
  assign row_last = ({1'b0, row_r} + 17'd1) >= {1'b0, h_eff};
  assign interior = (row_r >= 16'd2) && (col_r != '0) && !col_last;

  assign in_ready = run_r && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + 16'd1;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      run_r <= 1'b1;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line buffers are read ahead, at the column of the next sample
  assign rd_col  = rst_n ? col_nxt : '0;
  assign ua_addr = rd_col - CW'(1);
  assign ub_addr = rd_col;
  assign ma_addr = rd_col;
  assign mb_addr = rd_col + CW'(1);

  assign xs       = in_sample[VALUE_BITS-1:0];
  assign left_v   = byp_ua_r ? up_wd_r  : ua_q;
  assign up_v     = byp_ub_r ? up_wd_r  : ub_q;
  assign center_v = byp_ma_r ? mid_wd_r : ma_q;
  assign right_v  = byp_mb_r ? mid_wd_r : mb_q;

  jfs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk     (clk),
    .we      (accept),
    .waddr   (col_r),
    .wdata   (center_v),
    .raddr_a (ua_addr),
    .raddr_b (ub_addr),
    .rdata_a (ua_q),
    .rdata_b (ub_q)
  );

  jfs_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk     (clk),
    .we      (accept),
    .waddr   (col_r),
    .wdata   (xs),
    .raddr_a (ma_addr),
    .raddr_b (mb_addr),
    .rdata_a (ma_q),
    .rdata_b (mb_q)
  );

  // write-to-read forwarding for the edge at which a line entry is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_ua_r <= 1'b0;
      byp_ub_r <= 1'b0;
      byp_ma_r <= 1'b0;
      byp_mb_r <= 1'b0;
    end else begin
      byp_ua_r <= accept && (col_r == ua_addr);
      byp_ub_r <= accept && (col_r == ub_addr);
      byp_ma_r <= accept && (col_r == ma_addr);
      byp_mb_r <= accept && (col_r == mb_addr);
    end
  end

  always_ff @(posedge clk) begin
    up_wd_r  <= center_v;
    mid_wd_r <= xs;
  end

  assign q_push = accept && (interior || (col_last && row_last));

  always_comb begin
    q_item       = '0;
    q_item.last  = col_last && row_last;
    if (interior) begin
      q_item.left  = DATA_BITS'(left_v);
      q_item.up    = DATA_BITS'(up_v);
      q_item.right = DATA_BITS'(right_v);
      q_item.down  = DATA_BITS'(xs);
      q_item.old   = DATA_BITS'(center_v);
      q_item.row   = row_r - 16'd1;
      q_item.col   = COL_BITS'(col_r);
    end
  end

`ifndef SYNTH
  a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.last |=> (row_r == '0) && (col_r == '0))
    else $error("counters not cleared after the last sample of a sweep");
`endif

endmodule

// ===== rtl/core/jfs_back.sv =====
// ----------------------------------------------------------------------------
// jfs_back
// Stencil average, squared update and saturating residual; output register.
// ----------------------------------------------------------------------------
module jfs_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_empty,
  input  jfs_pkg::jfs_item_t                    q_head,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [jfs_pkg::DATA_BITS-1:0]  out_new_value,
  output logic [jfs_pkg::ROW_BITS-1:0]          out_row,
  output logic [jfs_pkg::COL_BITS-1:0]          out_col,
  output logic [jfs_pkg::RES_BITS-1:0]          out_residual,
  output logic                                  out_is_residual
);
  import jfs_pkg::*;

  logic en;

  logic                        s1_v_r;
  logic signed [DATA_BITS:0]   s1_sa_r;
  logic signed [DATA_BITS:0]   s1_sb_r;
  logic signed [DATA_BITS-1:0] s1_old_r;
  logic [ROW_BITS-1:0]         s1_row_r;
  logic [COL_BITS-1:0]         s1_col_r;
  logic                        s1_last_r;

  logic                        s2_v_r;
  logic signed [DATA_BITS-1:0] s2_nv_r;
  logic signed [DATA_BITS-1:0] s2_old_r;
  logic [ROW_BITS-1:0]         s2_row_r;
  logic [COL_BITS-1:0]         s2_col_r;
  logic                        s2_last_r;

  logic                        s3_v_r;
  logic signed [DATA_BITS-1:0] s3_nv_r;
  logic [DATA_BITS-1:0]        s3_ad_r;
  logic [ROW_BITS-1:0]         s3_row_r;
  logic [COL_BITS-1:0]         s3_col_r;
  logic                        s3_last_r;

  logic                        s4_v_r;
  logic signed [DATA_BITS-1:0] s4_nv_r;
  logic [2*DATA_BITS-1:0]      s4_sq_r;
  logic [ROW_BITS-1:0]         s4_row_r;
  logic [COL_BITS-1:0]         s4_col_r;
  logic                        s4_last_r;

  logic signed [DATA_BITS+1:0] sum4;
  logic signed [DATA_BITS:0]   d_pos;
  logic signed [DATA_BITS:0]   d_neg;
  logic [2*DATA_BITS-1:0]      sq;
  logic [RES_BITS+1:0]         acc;
  logic [RES_BITS-1:0]         total_r;
  logic [RES_BITS-1:0]         total_nxt;

  logic                        out_valid_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  assign sum4  = (DATA_BITS+2)'(s1_sa_r) + (DATA_BITS+2)'(s1_sb_r);
  assign d_pos = (DATA_BITS+1)'(s2_nv_r) - (DATA_BITS+1)'(s2_old_r);
  assign d_neg = (DATA_BITS+1)'(s2_old_r) - (DATA_BITS+1)'(s2_nv_r);
  assign sq    = (2*DATA_BITS)'(s3_ad_r) * (2*DATA_BITS)'(s3_ad_r);
  assign acc   = (RES_BITS+2)'(total_r) + (RES_BITS+2)'(s4_sq_r);
  assign total_nxt = (acc > (RES_BITS+2)'(RES_CAP)) ? RES_CAP : acc[RES_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else if (en) begin
      s1_v_r      <= !q_empty;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
      if (s4_v_r) begin
        total_r <= s4_last_r ? '0 : total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sa_r   <= (DATA_BITS+1)'(q_head.left) + (DATA_BITS+1)'(q_head.up);
      s1_sb_r   <= (DATA_BITS+1)'(q_head.right) + (DATA_BITS+1)'(q_head.down);
      s1_old_r  <= q_head.old;
      s1_row_r  <= q_head.row;
      s1_col_r  <= q_head.col;
      s1_last_r <= q_head.last;

      s2_nv_r   <= sum4[DATA_BITS+1:2];
      s2_old_r  <= s1_old_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_last_r <= s1_last_r;

      s3_nv_r   <= s2_nv_r;
      s3_ad_r   <= d_pos[DATA_BITS] ? d_neg[DATA_BITS-1:0] : d_pos[DATA_BITS-1:0];
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_last_r <= s2_last_r;

      s4_nv_r   <= s3_nv_r;
      s4_sq_r   <= sq;
      s4_row_r  <= s3_row_r;
      s4_col_r  <= s3_col_r;
      s4_last_r <= s3_last_r;

      if (s4_v_r) begin
        if (s4_last_r) begin
          out_new_value   <= '0;
          out_row         <= '0;
          out_col         <= '0;
          out_residual    <= total_r;
          out_is_residual <= 1'b1;
        end else begin
          out_new_value   <= s4_nv_r;
          out_row         <= s4_row_r;
          out_col         <= s4_col_r;
          out_residual    <= '0;
          out_is_residual <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    en && s4_v_r && s4_last_r |=> total_r == '0)
    else $error("residual total not cleared after the residual item");

  a_residual_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_is_residual |-> (out_new_value == '0) && (out_row == '0)
      && (out_col == '0))
    else $error("residual item carries point data");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !q_pop)
    else $error("queue popped while the output is stalled");
`endif

endmodule

// ===== rtl/core/jacobi_five_point_stencil.sv =====
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil
// Streaming five-point Jacobi update with a saturating squared residual.
// Throughput: one sample per cycle unless stalled; line buffers give one
// stencil per interior sample. Path: queue, stages s1-s4, output register.
// Reset: synchronous; counters, queue and residual clear, geometry 16 x 16.
// Line buffers are not cleared; each entry is written before it is read.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil #(
  parameter int MAX_WIDTH  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [jfs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [jfs_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [jfs_pkg::DATA_BITS-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [jfs_pkg::DATA_BITS-1:0]  out_new_value,
  output logic [jfs_pkg::ROW_BITS-1:0]          out_row,
  output logic [jfs_pkg::COL_BITS-1:0]          out_col,
  output logic [jfs_pkg::RES_BITS-1:0]          out_residual,
  output logic                                  out_is_residual
);
  import jfs_pkg::*;

  logic      q_push;
  jfs_item_t q_item;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  jfs_item_t q_head;

  jfs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  jfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  jfs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_value   (out_new_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_residual    (out_residual),
    .out_is_residual (out_is_residual)
  );

endmodule

// ===== tb/jacobi_five_point_stencil_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_tb
// Self-checking bench for the streaming five-point Jacobi stencil.
// Raster-order sweeps are fed over many grid geometries, including clamped
// register values and reshapes in the middle of a sweep. A local model of
// the line buffers predicts each interior average and the saturating
// squared residual of every sweep. Result items are compared field by field
// while the channels idle in random bursts in some phases.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_tb;
  import jfs_pkg::*;

  typedef struct {
    logic signed [DATA_BITS-1:0] value;
    logic [ROW_BITS-1:0]         row;
    logic [COL_BITS-1:0]         col;
    logic [RES_BITS-1:0]         resid;
    logic                        last;
  } point_t;

  typedef enum int {FILL_FULL, FILL_NEAR_ONE, FILL_EXTREME, FILL_MIXED} fill_t;

  localparam int          LINE_DEPTH = 1024;
  localparam logic [63:0] SUM_CAP    = {1'b0, RES_CAP};
  localparam logic signed [DATA_BITS-1:0] MIXED_GRID [9] = '{
    32'sh0000_0000, -32'sd1,        32'sh0001_0000,
    -32'sd2,        32'sh7FFF_FFFF, 32'sh0000_0003,
    32'shAAAA_AAAA, -32'sd3,        32'sh5555_5555
  };

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]     cfg_index = REG_GRID_WIDTH;
  logic [CFG_DATA_BITS-1:0]    cfg_wdata = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic signed [DATA_BITS-1:0] in_sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [DATA_BITS-1:0] out_new_value;
  logic [ROW_BITS-1:0]         out_row;
  logic [COL_BITS-1:0]         out_col;
  logic [RES_BITS-1:0]         out_residual;
  logic                        out_is_residual;

  logic signed [DATA_BITS-1:0] sample_q[$];
  point_t                      update_q[$];

  logic [GW_BITS-1:0]          grid_w = GRID_WIDTH_RST;
  logic [GH_BITS-1:0]          grid_h = GRID_HEIGHT_RST;
  logic signed [DATA_BITS-1:0] upper_line  [LINE_DEPTH];
  logic signed [DATA_BITS-1:0] middle_line [LINE_DEPTH];
  int unsigned                 col_cnt = 0;
  int unsigned                 row_cnt = 0;
  logic [63:0]                 sq_sum  = '0;

  int unsigned errors  = 0;
  int unsigned in_pct  = 0;
  int unsigned out_pct = 0;
  int unsigned in_gap  = 0;
  int unsigned out_gap = 0;

  jacobi_five_point_stencil u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_value   (out_new_value),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_residual    (out_residual),
    .out_is_residual (out_is_residual)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_width();
    if (grid_w < 3) return 3;
    if (grid_w > LINE_DEPTH) return LINE_DEPTH;
    return 32'(grid_w);
  endfunction

  function automatic int unsigned eff_height();
    if (grid_h < 3) return 3;
    return 32'(grid_h);
  endfunction

  // one raster sample in: update the line buffers, counters and residual
  function automatic void relax_sample(input logic signed [DATA_BITS-1:0] x);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    longint      avg;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] sq;
    point_t      p;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    if (r >= 2 && c >= 1 && c + 1 < w) begin
      avg = (longint'(upper_line[c-1]) + longint'(upper_line[c]) +
             longint'(middle_line[c+1]) + longint'(x)) >>> 2;
      diff = avg - longint'(middle_line[c]);
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
      sq_sum = (sq > SUM_CAP - sq_sum) ? SUM_CAP : sq_sum + sq;
      p.value = avg[DATA_BITS-1:0];
      p.row   = ROW_BITS'(r - 1);
      p.col   = COL_BITS'(c);
      p.resid = '0;
      p.last  = 1'b0;
      update_q.push_back(p);
    end
    upper_line[c]  = middle_line[c];
    middle_line[c] = x;
    if (c + 1 >= w) begin
      col_cnt = 0;
      if (r + 1 >= h) begin
        p.value = '0;
        p.row   = '0;
        p.col   = '0;
        p.resid = sq_sum[RES_BITS-1:0];
        p.last  = 1'b1;
        update_q.push_back(p);
        row_cnt = 0;
        sq_sum  = '0;
      end else begin
        row_cnt = r + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic logic signed [DATA_BITS-1:0] draw_sample(input fill_t fill);
    logic signed [DATA_BITS-1:0] v;
    fill_t                       f;
    f = (fill == FILL_MIXED) ? fill_t'($urandom_range(2)) : fill;
    case (f)
      FILL_NEAR_ONE: begin
        v = $urandom_range(32'h0004_0000);
        return v - 32'sh0002_0000;
      end
      FILL_EXTREME: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return '0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_samples(input int unsigned n, input fill_t fill);
    repeat (n) sample_q.push_back(draw_sample(fill));
  endfunction

  // finish the sweep in progress, then add whole sweeps; counters must be idle
  function automatic int unsigned queue_sweeps(input int unsigned sweeps, input fill_t fill);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    w = eff_width();
    h = eff_height();
    n = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
    if (row_cnt + 1 < h) n += (h - 1 - row_cnt) * w;
    n += (sweeps - 1) * w * h;
    push_samples(n, fill);
    return n;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_WIDTH) grid_w = data[GW_BITS-1:0];
    else grid_h = data[GH_BITS-1:0];
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || in_valid || update_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) relax_sample(in_sample);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0 && in_pct != 0 && $urandom_range(99) < in_pct) begin
          in_gap = $urandom_range(5);
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    point_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (update_q.size() == 0) begin
          flag_mismatch("item with none pending",
                        64'({out_is_residual, out_row, out_col}), '0);
        end else begin
          want = update_q.pop_front();
          if (out_new_value !== want.value)
            flag_mismatch("new_value", 64'(out_new_value), 64'(want.value));
          if (out_row !== want.row)
            flag_mismatch("row", 64'(out_row), 64'(want.row));
          if (out_col !== want.col)
            flag_mismatch("col", 64'(out_col), 64'(want.col));
          if (out_residual !== want.resid)
            flag_mismatch("residual", 64'(out_residual), 64'(want.resid));
          if (out_is_residual !== want.last)
            flag_mismatch("is_residual", 64'(out_is_residual), 64'(want.last));
        end
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (out_pct != 0 && $urandom_range(99) < out_pct) begin
        out_gap = $urandom_range(5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned made;
    int unsigned k;
    fill_t       fill;
    foreach (upper_line[i]) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3 x 3 grids from out-of-range register values
    write_reg(REG_GRID_WIDTH, 16'd0);
    write_reg(REG_GRID_HEIGHT, 16'd1);
    repeat (9) sample_q.push_back(32'sh7FFF_FFFF);
    for (int i = 0; i < 9; i++)
      sample_q.push_back(i == 4 ? 32'sh7FFF_FFFF : 32'sh8000_0000);
    settle();
    write_reg(REG_GRID_WIDTH, 16'd2);
    write_reg(REG_GRID_HEIGHT, 16'd2);
    foreach (MIXED_GRID[i]) sample_q.push_back(MIXED_GRID[i]);
    settle();

    made = 0;
    while (made < 350) begin
      in_pct  = 15 * $urandom_range(2);
      out_pct = 15 * $urandom_range(2);
      k = $urandom_range(9);
      write_reg(REG_GRID_WIDTH,
                CFG_DATA_BITS'((k == 0) ? $urandom_range(2) :
                               (k == 1) ? $urandom_range(17, 40) :
                                          $urandom_range(3, 16)));
      write_reg(REG_GRID_HEIGHT,
                CFG_DATA_BITS'((k == 2) ? $urandom_range(2) : $urandom_range(3, 9)));
      fill = fill_t'($urandom_range(3));
      if ($urandom_range(3) == 0) begin
        // stop partway, reshape the grid, then finish the sweep
        k = $urandom_range(1, eff_width() * eff_height() - 1);
        push_samples(k, fill);
        made += k;
        settle();
        if ($urandom_range(1) != 0)
          write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'($urandom_range(8)));
        else
          write_reg(REG_GRID_WIDTH, CFG_DATA_BITS'($urandom_range(eff_width())));
      end
      made += queue_sweeps($urandom_range(1, 2), fill);
      settle();
    end

    // tallest height, cut short; upper width bits are ignored
    in_pct  = 15;
    out_pct = 15;
    write_reg(REG_GRID_WIDTH, 16'hF805);
    write_reg(REG_GRID_HEIGHT, 16'hFFFF);
    push_samples(38, FILL_FULL);
    settle();
    write_reg(REG_GRID_HEIGHT, 16'd4);
    void'(queue_sweeps(1, FILL_FULL));
    settle();

    // over-range width clamps to the full line; one row and one sample, then narrow
    write_reg(REG_GRID_WIDTH, 16'h07FF);
    write_reg(REG_GRID_HEIGHT, 16'd3);
    push_samples(LINE_DEPTH + 1, FILL_NEAR_ONE);
    settle();
    write_reg(REG_GRID_WIDTH, 16'd3);
    void'(queue_sweeps(1, FILL_NEAR_ONE));
    settle();

    in_pct  = 0;
    out_pct = 0;
    write_reg(REG_GRID_WIDTH, 16'd7);
    write_reg(REG_GRID_HEIGHT, 16'd5);
    void'(queue_sweeps(2, FILL_FULL));
    settle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
